@@ hdl/hrp_pkg.sv @@
// types, constants and character tables shared by the request parser
package hrp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD     = 4'd0,
    PH_URL_FIRST  = 4'd1,
    PH_URL_PREFIX = 4'd2,
    PH_URL_HOST   = 4'd3,
    PH_URL_PATH   = 4'd4,
    PH_VERSION    = 4'd5,
    PH_HDR_NAME   = 4'd6,
    PH_CONN_WS    = 4'd7,
    PH_CONN_VAL   = 4'd8,
    PH_LEN_WS     = 4'd9,
    PH_LEN_VAL    = 4'd10,
    PH_HDR_SKIP   = 4'd11,
    PH_BODY       = 4'd12
  } hrp_phase_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] GET_LEN     = 4'd3;
  localparam logic [3:0] SCHEME_LEN  = 4'd7;
  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [3:0] KEEP_LEN    = 4'd10;
  localparam logic [3:0] CONN_LEN    = 4'd11;
  localparam logic [3:0] CLEN_LEN    = 4'd15;

  // header_cand bit 0 tracks Connection, bit 1 Content-Length
  typedef struct packed {
    hrp_phase_t  phase;
    logic [3:0]  match_pos;
    logic [1:0]  header_cand;
    logic        cr_seen;
    logic        value_matching;
    logic        keep_alive;
    logic        line_empty;
  } hrp_state_t;

  localparam hrp_state_t STATE_RESET = '{
    phase: PH_METHOD, match_pos: 4'd0, header_cand: 2'b11, cr_seen: 1'b0,
    value_matching: 1'b0, keep_alive: 1'b0, line_empty: 1'b1
  };

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] get_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h67; // g
      4'd1:    return 8'h65; // e
      4'd2:    return 8'h74; // t
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] scheme_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h68; // h
      4'd1:    return 8'h74; // t
      4'd2:    return 8'h74; // t
      4'd3:    return 8'h70; // p
      4'd4:    return 8'h3a; // :
      4'd5:    return 8'h2f; // /
      4'd6:    return 8'h2f; // /
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] version_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h68; // h
      4'd1:    return 8'h74; // t
      4'd2:    return 8'h74; // t
      4'd3:    return 8'h70; // p
      4'd4:    return 8'h2f; // /
      4'd5:    return 8'h31; // 1
      4'd6:    return 8'h2e; // .
      4'd7:    return 8'h31; // 1
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h63; // c
      4'd1:    return 8'h6f; // o
      4'd2:    return 8'h6e; // n
      4'd3:    return 8'h6e; // n
      4'd4:    return 8'h65; // e
      4'd5:    return 8'h63; // c
      4'd6:    return 8'h74; // t
      4'd7:    return 8'h69; // i
      4'd8:    return 8'h6f; // o
      4'd9:    return 8'h6e; // n
      4'd10:   return 8'h3a; // :
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] clen_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h63; // c
      4'd1:    return 8'h6f; // o
      4'd2:    return 8'h6e; // n
      4'd3:    return 8'h74; // t
      4'd4:    return 8'h65; // e
      4'd5:    return 8'h6e; // n
      4'd6:    return 8'h74; // t
      4'd7:    return 8'h2d; // -
      4'd8:    return 8'h6c; // l
      4'd9:    return 8'h65; // e
      4'd10:   return 8'h6e; // n
      4'd11:   return 8'h67; // g
      4'd12:   return 8'h74; // t
      4'd13:   return 8'h68; // h
      4'd14:   return 8'h3a; // :
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] keep_char(input logic [3:0] i);
    case (i)
      4'd0:    return 8'h6b; // k
      4'd1:    return 8'h65; // e
      4'd2:    return 8'h65; // e
      4'd3:    return 8'h70; // p
      4'd4:    return 8'h2d; // -
      4'd5:    return 8'h61; // a
      4'd6:    return 8'h6c; // l
      4'd7:    return 8'h69; // i
      4'd8:    return 8'h76; // v
      4'd9:    return 8'h65; // e
      default: return 8'h00;
    endcase
  endfunction

endpackage

@@ hdl/hrp_if.sv @@
// valid/ready channel interfaces for request bytes and parse results
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        path_valid;
  logic [7:0]  path_byte;
  logic        keep_alive;
  logic [31:0] content_length;
  modport source (output valid, output status, output path_valid, output path_byte,
                  output keep_alive, output content_length, input ready);
  modport sink (input valid, input status, input path_valid, input path_byte,
                input keep_alive, input content_length, output ready);
endinterface

@@ hdl/hrp_step.sv @@
// per-byte parser update: next state and result fields for one byte
module hrp_step
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  hrp_state_t             st,
  input  logic [LENGTH_BITS-1:0] len,
  input  logic [LENGTH_BITS-1:0] body,
  input  logic [7:0]             data_byte,
  output hrp_state_t             st_nxt,
  output logic [LENGTH_BITS-1:0] len_nxt,
  output logic [LENGTH_BITS-1:0] body_nxt,
  output logic [1:0]             status,
  output logic                   emit,
  output logic                   keep_alive,
  output logic [LENGTH_BITS-1:0] len_out
);

  hrp_state_t             su;
  logic [LENGTH_BITS-1:0] lu;
  logic [LENGTH_BITS-1:0] bu;
  logic [7:0]             lb;
  logic [3:0]             mp;
  logic [1:0]             cand;
  logic [LENGTH_BITS+3:0] scaled;

  // length times ten plus digit, overflow shows in the top four bits
  assign scaled = {1'b0, len, 3'b000} + {3'b000, len, 1'b0}
                + {{(LENGTH_BITS){1'b0}}, data_byte[3:0] - CH_ZERO[3:0]};

  always_comb begin
    su     = st;
    lu     = len;
    bu     = body;
    status = ST_BUSY;
    emit   = 1'b0;
    lb     = to_lower(data_byte);
    mp     = st.match_pos;
    cand   = st.header_cand;

    if (st.phase == PH_BODY) begin
      // body bytes only count down
      if (body != '0) bu = body - 1'b1;
      status = (bu == '0) ? ST_DONE : ST_BUSY;
    end else if (st.cr_seen) begin
      // line end handling
      su.cr_seen = 1'b0;
      if (data_byte != CH_LF) begin
        status = ST_BAD;
      end else begin
        case (st.phase)
          PH_VERSION: begin
            if (st.match_pos == VERSION_LEN) begin
              su.phase = PH_HDR_NAME; su.match_pos = '0; su.header_cand = 2'b11;
              su.value_matching = 1'b0; su.line_empty = 1'b1;
            end else begin
              status = ST_BAD;
            end
          end
          PH_HDR_NAME, PH_CONN_WS, PH_CONN_VAL, PH_LEN_WS, PH_LEN_VAL, PH_HDR_SKIP: begin
            if (st.line_empty) begin
              if (len != '0) begin
                su.phase = PH_BODY;
                bu = len;
              end else begin
                status = ST_DONE;
              end
            end else begin
              if (st.phase == PH_CONN_VAL && st.value_matching && st.match_pos == KEEP_LEN)
                su.keep_alive = 1'b1;
              su.phase = PH_HDR_NAME; su.match_pos = '0; su.header_cand = 2'b11;
              su.value_matching = 1'b0; su.line_empty = 1'b1;
            end
          end
          default: status = ST_BAD;
        endcase
      end
    end else if (data_byte == CH_CR) begin
      su.cr_seen = 1'b1;
    end else if (data_byte == CH_LF) begin
      status = ST_BAD;
    end else begin
      // ordinary line byte
      case (st.phase)
        PH_METHOD: begin
          if (mp < GET_LEN && lb == get_char(mp)) begin
            su.match_pos = mp + 1'b1;
          end else if (mp == GET_LEN && is_blank(data_byte)) begin
            su.phase = PH_URL_FIRST; su.match_pos = '0;
          end else begin
            status = ST_BAD;
          end
        end
        PH_URL_FIRST: begin
          if (data_byte == CH_SLASH) begin
            su.phase = PH_URL_PATH; emit = 1'b1;
          end else if (lb == CH_H) begin
            su.phase = PH_URL_PREFIX; su.match_pos = 4'd1;
          end else begin
            status = ST_BAD;
          end
        end
        PH_URL_PREFIX: begin
          if (mp < SCHEME_LEN && lb == scheme_char(mp)) begin
            su.match_pos = mp + 1'b1;
            if (mp + 1'b1 == SCHEME_LEN) su.phase = PH_URL_HOST;
          end else begin
            status = ST_BAD;
          end
        end
        PH_URL_HOST: begin
          if (data_byte == CH_SLASH) begin
            su.phase = PH_URL_PATH; emit = 1'b1;
          end else if (is_blank(data_byte)) begin
            status = ST_BAD;
          end
        end
        PH_URL_PATH: begin
          if (is_blank(data_byte)) begin
            su.phase = PH_VERSION; su.match_pos = '0;
          end else begin
            emit = 1'b1;
          end
        end
        PH_VERSION: begin
          if (mp < VERSION_LEN && lb == version_char(mp)) su.match_pos = mp + 1'b1;
          else status = ST_BAD;
        end
        PH_HDR_NAME: begin
          // narrow down the header names still possible
          su.line_empty = 1'b0;
          if (mp >= CLEN_LEN || lb != clen_char(mp)) cand[1] = 1'b0;
          if (mp >= CONN_LEN || lb != conn_char(mp)) cand[0] = 1'b0;
          su.header_cand = cand;
          su.match_pos   = mp + 1'b1;
          if (cand[0] && mp + 1'b1 == CONN_LEN) begin
            su.phase = PH_CONN_WS;
          end else if (cand[1] && mp + 1'b1 == CLEN_LEN) begin
            su.phase = PH_LEN_WS;
            lu = '0;
          end else if (cand == 2'b00) begin
            su.phase = PH_HDR_SKIP;
          end
        end
        PH_CONN_WS, PH_CONN_VAL: begin
          su.line_empty = 1'b0;
          if (!(st.phase == PH_CONN_WS && is_blank(data_byte))) begin
            // first value byte restarts the keep-alive match
            if (st.phase == PH_CONN_WS) begin
              su.phase = PH_CONN_VAL;
              mp = '0;
              su.value_matching = 1'b1;
              su.match_pos = '0;
            end
            if (su.value_matching && mp < KEEP_LEN && lb == keep_char(mp))
              su.match_pos = mp + 1'b1;
            else
              su.value_matching = 1'b0;
          end
        end
        PH_LEN_WS, PH_LEN_VAL: begin
          su.line_empty = 1'b0;
          if (!(st.phase == PH_LEN_WS && is_blank(data_byte))) begin
            if (st.phase == PH_LEN_WS) begin
              su.phase = PH_LEN_VAL;
              su.value_matching = 1'b1;
            end
            if (su.value_matching && data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
              // saturate once the value would overflow
              if (scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) lu = '1;
              else lu = scaled[LENGTH_BITS-1:0];
            end else begin
              su.value_matching = 1'b0;
            end
          end
        end
        PH_HDR_SKIP: su.line_empty = 1'b0;
        default:     status = ST_BAD;
      endcase
    end

    // a finished or bad request restarts the parser
    keep_alive = su.keep_alive;
    len_out    = lu;
    if (status != ST_BUSY) begin
      st_nxt   = STATE_RESET;
      len_nxt  = '0;
      body_nxt = '0;
    end else begin
      st_nxt   = su;
      len_nxt  = lu;
      body_nxt = bu;
    end
  end

endmodule

@@ hdl/http_request_parser_unit.sv @@
// top level of the request parser: input register, byte update, result register
//
// Request bytes enter on in_ch, one beat per byte; every byte yields exactly one
// result beat on out_ch with status (busy, complete, bad), an optional URL path
// byte, the keep-alive flag and the Content-Length value so far.
// An accepted byte first sits in the input register, then the per-byte update writes
// the parser state and the result register together. One byte per cycle is sustained
// while out_ch does not stall; the parser state loop (phase, match position, length
// accumulator) closes through the combinational per-byte update and the state register.
// After a complete or bad result the parser restarts from its reset state on
// the next byte.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the method phase with keep-alive and lengths cleared.
// When out_ch stalls, the result register holds and the input register still
// takes one byte; in_ch.ready drops only when both are full.
module http_request_parser_unit
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hrp_in_if.sink     in_ch,
  hrp_out_if.source  out_ch
);

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   out_vld_r;
  logic [1:0]             status_r;
  logic                   path_vld_r;
  logic [7:0]             path_byte_r;
  logic                   keep_r;
  logic [31:0]            clen_r;
  hrp_state_t             st_r;
  hrp_state_t             st_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_nxt;
  logic [LENGTH_BITS-1:0] body_r;
  logic [LENGTH_BITS-1:0] body_nxt;
  logic [1:0]             status_nxt;
  logic                   emit_nxt;
  logic                   keep_nxt;
  logic [LENGTH_BITS-1:0] len_out;
  logic [LENGTH_BITS+31:0] len_ext;
  logic                   out_free;
  logic                   adv;

  // handshake between the two register stages
  assign out_free    = !out_vld_r || out_ch.ready;
  assign adv         = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || out_free;

  hrp_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .st         (st_r),
    .len        (len_r),
    .body       (body_r),
    .data_byte  (in_byte_r),
    .st_nxt     (st_nxt),
    .len_nxt    (len_nxt),
    .body_nxt   (body_nxt),
    .status     (status_nxt),
    .emit       (emit_nxt),
    .keep_alive (keep_nxt),
    .len_out    (len_out)
  );

  assign len_ext = {32'd0, len_out};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) in_byte_r <= in_ch.data_byte;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= STATE_RESET;
      len_r  <= '0;
      body_r <= '0;
    end else if (adv) begin
      st_r   <= st_nxt;
      len_r  <= len_nxt;
      body_r <= body_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (adv) begin
      status_r    <= status_nxt;
      path_vld_r  <= emit_nxt;
      path_byte_r <= emit_nxt ? in_byte_r : 8'd0;
      keep_r      <= keep_nxt;
      clen_r      <= len_ext[31:0];
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = status_r;
  assign out_ch.path_valid     = path_vld_r;
  assign out_ch.path_byte      = path_byte_r;
  assign out_ch.keep_alive     = keep_r;
  assign out_ch.content_length = clen_r;

  // a path byte only comes while the request is still in progress
  a_path_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && path_vld_r |-> status_r == ST_BUSY)
    else $error("path byte reported with a final status");

  // a final status restarts the parser
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && status_nxt != ST_BUSY |=> st_r.phase == PH_METHOD && len_r == '0 && body_r == '0)
    else $error("parser did not restart after a final status");

  // the body phase always has bytes left
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_BODY |-> body_r != '0)
    else $error("body phase with nothing remaining");

  // a free result register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_free |-> in_ch.ready)
    else $error("input stalled while the result register is free");

endmodule
